@@ sv/command_frame_deframer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Command frame deframer assertion macros
// Shared property forms for the checker of the deframer's ports.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define COMMAND_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define CFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define CFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

@@ sv/cfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Command frame deframer package
// Types, command codes and frame layout constants shared by the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

  typedef enum logic [3:0] {
    CMD_UNKNOWN  = 4'd0,
    CMD_DEPLOY   = 4'd1,
    CMD_DATE     = 4'd2,
    CMD_EMPTY    = 4'd3,
    CMD_MISSION  = 4'd4,
    CMD_MEETING  = 4'd5,
    CMD_MEASURE  = 4'd6,
    CMD_SAVE     = 4'd7,
    CMD_SURVIVAL = 4'd8,
    CMD_STATUS   = 4'd9
  } cmd_e;

  typedef enum logic [0:0] {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_id;
    cmd_e       command;
    logic       checksum_ok;
  } result_t;

  localparam logic [7:0] MARKER_RESET = 8'd126;

  localparam logic [7:0] POS_ID   = 8'd1;
  localparam logic [7:0] POS_LEN  = 8'd2;
  localparam logic [7:0] POS_CMD0 = 8'd3;
  localparam logic [7:0] POS_CMD1 = 8'd4;
  localparam logic [7:0] POS_CMD2 = 8'd5;
  localparam logic [7:0] MIN_LEN  = 8'd3;

  localparam logic [7:0] CHR_A = 8'h41;
  localparam logic [7:0] CHR_D = 8'h44;
  localparam logic [7:0] CHR_E = 8'h45;
  localparam logic [7:0] CHR_I = 8'h49;
  localparam logic [7:0] CHR_M = 8'h4D;
  localparam logic [7:0] CHR_S = 8'h53;
  localparam logic [7:0] CHR_T = 8'h54;
  localparam logic [7:0] CHR_U = 8'h55;

  // Payload start position is three plus the keyword length.
  localparam logic [3:0] PS_RESET    = 4'd3;
  localparam logic [3:0] PS_DEPLOY   = 4'd9;
  localparam logic [3:0] PS_DATE     = 4'd7;
  localparam logic [3:0] PS_EMPTY    = 4'd8;
  localparam logic [3:0] PS_MISSION  = 4'd10;
  localparam logic [3:0] PS_MEETING  = 4'd10;
  localparam logic [3:0] PS_MEASURE  = 4'd10;
  localparam logic [3:0] PS_SAVE     = 4'd7;
  localparam logic [3:0] PS_SURVIVAL = 4'd11;
  localparam logic [3:0] PS_STATUS   = 4'd9;

endpackage

`default_nettype wire

@@ sv/cfd_input_stage.sv @@
// ----------------------------------------------------------------------------
// Command frame deframer input stage
// Registers one received byte and holds it while the result side is full.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_input_stage import cfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       out_ready_i,
  output logic            stage_valid_o,
  output logic [7:0]      stage_byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_stall_o    = valid_q && !out_ready_i;
  assign stage_valid_o = valid_q;
  assign stage_byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/cfd_parser.sv @@
// ----------------------------------------------------------------------------
// Command frame deframer parser
// Tracks the frame position, classifies the command word, accumulates the
// checksum and forms one result item per payload byte or frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_parser import cfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_marker_i,
  input  wire logic       advance_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  logic [7:0]  marker_val_q;
  logic        in_frame_q,   in_frame_d;
  logic [7:0]  position_q,   position_d;
  logic [7:0]  length_q,     length_d;
  logic [7:0]  xor_q,        xor_d;
  logic [7:0]  id_q,         id_d;
  logic [15:0] letters_q,    letters_d;
  cmd_e        cmd_q,        cmd_d;
  logic [3:0]  pstart_q,     pstart_d;

  cmd_e        cmd_c;
  logic [3:0]  pstart_c;
  logic [15:0] letters_c;

  always_comb begin
    cmd_c     = cmd_q;
    pstart_c  = pstart_q;
    letters_c = letters_q;
    case (position_q)
      POS_CMD0: begin
        letters_c = {8'h00, rx_byte_i};
        if (rx_byte_i == CHR_E) begin
          cmd_c    = CMD_EMPTY;
          pstart_c = PS_EMPTY;
        end
      end
      POS_CMD1: begin
        letters_c = {rx_byte_i, letters_q[7:0]};
        case (letters_q[7:0])
          CHR_D: begin
            if (rx_byte_i == CHR_E) begin
              cmd_c    = CMD_DEPLOY;
              pstart_c = PS_DEPLOY;
            end else if (rx_byte_i == CHR_A) begin
              cmd_c    = CMD_DATE;
              pstart_c = PS_DATE;
            end
          end
          CHR_S: begin
            if (rx_byte_i == CHR_A) begin
              cmd_c    = CMD_SAVE;
              pstart_c = PS_SAVE;
            end else if (rx_byte_i == CHR_U) begin
              cmd_c    = CMD_SURVIVAL;
              pstart_c = PS_SURVIVAL;
            end else if (rx_byte_i == CHR_T) begin
              cmd_c    = CMD_STATUS;
              pstart_c = PS_STATUS;
            end
          end
          CHR_M: begin
            if (rx_byte_i == CHR_I) begin
              cmd_c    = CMD_MISSION;
              pstart_c = PS_MISSION;
            end
          end
          default: ;
        endcase
      end
      POS_CMD2: begin
        if (letters_q[7:0] == CHR_M && letters_q[15:8] == CHR_E) begin
          if (rx_byte_i == CHR_E) begin
            cmd_c    = CMD_MEETING;
            pstart_c = PS_MEETING;
          end else if (rx_byte_i == CHR_A) begin
            cmd_c    = CMD_MEASURE;
            pstart_c = PS_MEASURE;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    in_frame_d  = in_frame_q;
    position_d  = position_q;
    length_d    = length_q;
    xor_d       = xor_q;
    id_d        = id_q;
    letters_d   = letters_q;
    cmd_d       = cmd_q;
    pstart_d    = pstart_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_PAYLOAD, payload_byte: 8'h00, frame_id: id_q,
                    command: cmd_q, checksum_ok: 1'b0};
    if (advance_i) begin
      if (!in_frame_q) begin
        if (rx_byte_i == marker_val_q) begin
          in_frame_d = 1'b1;
          position_d = POS_ID;
          length_d   = 8'h00;
          xor_d      = rx_byte_i;
          id_d       = 8'h00;
          letters_d  = 16'h0000;
          cmd_d      = CMD_UNKNOWN;
          pstart_d   = PS_RESET;
        end
      end else if (position_q == POS_ID) begin
        id_d       = rx_byte_i;
        xor_d      = xor_q ^ rx_byte_i;
        position_d = POS_LEN;
      end else if (position_q == POS_LEN) begin
        length_d = rx_byte_i;
        xor_d    = xor_q ^ rx_byte_i;
        if (rx_byte_i < MIN_LEN) begin
          cmd_d        = CMD_UNKNOWN;
          in_frame_d   = 1'b0;
          position_d   = 8'h00;
          res_valid_o  = 1'b1;
          res_o.kind    = KIND_SUMMARY;
          res_o.command = CMD_UNKNOWN;
        end else begin
          position_d = POS_CMD0;
        end
      end else if (position_q == length_q) begin
        in_frame_d        = 1'b0;
        position_d        = 8'h00;
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_SUMMARY;
        res_o.checksum_ok = (xor_q == rx_byte_i);
      end else begin
        xor_d      = xor_q ^ rx_byte_i;
        letters_d  = letters_c;
        cmd_d      = cmd_c;
        pstart_d   = pstart_c;
        position_d = position_q + 8'd1;
        if (cmd_c != CMD_UNKNOWN && position_q >= {4'h0, pstart_c} &&
            ({1'b0, position_q} + 9'd2) <= {1'b0, length_q}) begin
          res_valid_o        = 1'b1;
          res_o.payload_byte = rx_byte_i;
          res_o.command      = cmd_c;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_val_q <= MARKER_RESET;
      in_frame_q   <= 1'b0;
      position_q   <= 8'h00;
      length_q     <= 8'h00;
      xor_q        <= 8'h00;
      id_q         <= 8'h00;
      letters_q    <= 16'h0000;
      cmd_q        <= CMD_UNKNOWN;
      pstart_q     <= PS_RESET;
    end else begin
      if (cfg_we_i) begin
        marker_val_q <= cfg_marker_i;
      end
      in_frame_q <= in_frame_d;
      position_q <= position_d;
      length_q   <= length_d;
      xor_q      <= xor_d;
      id_q       <= id_d;
      letters_q  <= letters_d;
      cmd_q      <= cmd_d;
      pstart_q   <= pstart_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/cfd_output_stage.sv @@
// ----------------------------------------------------------------------------
// Command frame deframer output stage
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_output_stage import cfd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_valid_i,
  input  result_t   res_i,
  output logic      out_ready_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output result_t   out_o
);

  logic    valid_q;
  result_t data_q;

  assign out_ready_o = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/command_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// Command frame deframer
// Extracts payload bytes and a frame summary from a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
// One byte enters per item on the input channel (in_valid_i, in_stall_o,
// rx_byte_i). Bytes are dropped until one equals the start marker. Each
// payload byte of a known command leaves as a kind 0 item, and the checksum
// byte yields one kind 1 summary item with the id, command and checksum
// verdict. The start marker is written through cfg_valid_i, cfg_ready_o and
// cfg_start_marker_i; the port is always ready. The user must see that it is
// written only while idle; the block itself does not enforce this. A result
// item passes from the input register through the parser into the output
// register. One byte is taken every cycle while out_stall_i does not hold a
// full output register; the single parse stage between the input register
// and the output register sets that rate. While out_stall_i holds a full
// output register, the input register fills and in_stall_o rises, so no item
// is lost. Reset is asynchronous and active low: it empties both registers,
// returns the parser to idle and restores the start marker to a tilde.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_deframer_top import cfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_start_marker_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            kind_o,
  output logic [7:0]      payload_byte_o,
  output logic [7:0]      frame_id_o,
  output logic [3:0]      command_o,
  output logic            checksum_ok_o
);

  logic       out_ready;
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign cfg_ready_o = 1'b1;

  cfd_input_stage u_input (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_ready_i  (out_ready),
    .stage_valid_o(stage_valid),
    .stage_byte_o (stage_byte)
  );

  cfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_marker_i(cfg_start_marker_i),
    .advance_i   (stage_valid && out_ready),
    .rx_byte_i   (stage_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  cfd_output_stage u_output (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .out_ready_o(out_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_res)
  );

  assign kind_o         = out_res.kind;
  assign payload_byte_o = out_res.payload_byte;
  assign frame_id_o     = out_res.frame_id;
  assign command_o      = out_res.command;
  assign checksum_ok_o  = out_res.checksum_ok;

endmodule

`default_nettype wire

@@ sv/cfd_checker.sv @@
// ----------------------------------------------------------------------------
// Command frame deframer checker
// Port-level properties of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "command_frame_deframer_top_defines.svh"

module cfd_checker import cfd_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_o,
  input wire logic [7:0] cfg_start_marker_i,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] rx_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       kind_o,
  input wire logic [7:0] payload_byte_o,
  input wire logic [7:0] frame_id_o,
  input wire logic [3:0] command_o,
  input wire logic       checksum_ok_o
);

  logic unused_ports;
  assign unused_ports = cfg_valid_i ^ cfg_ready_o ^ (^cfg_start_marker_i) ^
                        in_valid_i ^ (^rx_byte_i) ^ (^frame_id_o);

  `CFD_ASSERT_NOW(a_summary_no_data, out_valid_o && kind_o, payload_byte_o == 8'h00)
  `CFD_ASSERT_NOW(a_payload_known_cmd, out_valid_o && !kind_o,
                  !checksum_ok_o && command_o != CMD_UNKNOWN)
  `CFD_ASSERT_NOW(a_cmd_range, out_valid_o, command_o <= CMD_STATUS)
  `CFD_ASSERT_NOW(a_stall_only_when_full, in_stall_o, out_valid_o && out_stall_i)
  `CFD_ASSERT_NEXT(a_out_holds, out_valid_o && out_stall_i, out_valid_o)

endmodule

bind command_frame_deframer_top cfd_checker u_cfd_checker (.*);

`default_nettype wire

@@ tb/command_frame_deframer_top_tb.sv @@
// ----------------------------------------------------------------------------
// Command frame deframer testbench
// A directed table, then random frames with correct and broken checksums,
// noise and cut-off frames. Each accepted byte goes through a behavioral
// deframer, and each output item is compared with the oldest pending
// expectation. The start marker is changed between phases, and from its second
// change on, the idle patterns and back-pressure change with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module command_frame_deframer_top_tb;
  import cfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_BYTES  = 290;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [7:0] rx;
    logic       fixed;
    logic       emits;
    result_t    res;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;

  localparam stim_row_t DIRECTED_ROWS [28] = '{
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h7E, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b1, '{KIND_SUMMARY, 8'h00, 8'hFF, CMD_UNKNOWN, 1'b0}},
    '{8'h7E, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h02, 1'b1, 1'b1, '{KIND_SUMMARY, 8'h00, 8'h00, CMD_UNKNOWN, 1'b0}},
    '{8'h7E, 1'b0, 1'b0, NO_RESULT},
    '{8'h7E, 1'b0, 1'b0, NO_RESULT},
    '{8'h03, 1'b0, 1'b0, NO_RESULT},
    '{8'h03, 1'b1, 1'b1, '{KIND_SUMMARY, 8'h00, 8'h7E, CMD_UNKNOWN, 1'b1}},
    '{8'h7E, 1'b0, 1'b0, NO_RESULT},
    '{8'h11, 1'b0, 1'b0, NO_RESULT},
    '{8'h04, 1'b0, 1'b0, NO_RESULT},
    '{8'h45, 1'b0, 1'b0, NO_RESULT},
    '{8'h2E, 1'b1, 1'b1, '{KIND_SUMMARY, 8'h00, 8'h11, CMD_EMPTY, 1'b1}},
    '{8'h7E, 1'b0, 1'b0, NO_RESULT},
    '{8'h5A, 1'b0, 1'b0, NO_RESULT},
    '{8'h0A, 1'b0, 1'b0, NO_RESULT},
    '{8'h44, 1'b0, 1'b0, NO_RESULT},
    '{8'h41, 1'b0, 1'b0, NO_RESULT},
    '{8'h54, 1'b0, 1'b0, NO_RESULT},
    '{8'h45, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h7E, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_start_marker_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       kind_o;
  logic [7:0] payload_byte_o;
  logic [7:0] frame_id_o;
  logic [3:0] command_o;
  logic       checksum_ok_o;

  command_frame_deframer_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_start_marker_i(cfg_start_marker_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .payload_byte_o    (payload_byte_o),
    .frame_id_o        (frame_id_o),
    .command_o         (command_o),
    .checksum_ok_o     (checksum_ok_o)
  );

  // Shadow deframer state.
  logic [7:0] marker_q    = MARKER_RESET;
  logic       pf_active   = 1'b0;
  logic [7:0] pf_pos      = 8'd0;
  logic [7:0] pf_len      = 8'd0;
  logic [7:0] pf_xor      = 8'd0;
  logic [7:0] pf_id       = 8'd0;
  logic [7:0] pf_c0       = 8'd0;
  logic [7:0] pf_c1       = 8'd0;
  cmd_e       pf_cmd      = CMD_UNKNOWN;
  logic [7:0] pf_start    = 8'd3;

  result_t     pending_results [$];
  logic [7:0]  frame_bytes [$];
  int unsigned errors        = 0;
  int unsigned cycle_count   = 0;
  int unsigned phase_bytes   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request  = 1'b0;
  int unsigned hold_left     = 0;

  string keywords [0:8] = '{"DEPLOY", "DATE", "EMPTY", "MISSION", "MEETING",
                            "MEASURE", "SAVE", "SURVIVAL", "STATUS"};
  string letters = "DEAMISUT";

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("command_frame_deframer_top_tb: errors");
      $finish;
    end
  end

  function automatic void set_command(input cmd_e code, input int unsigned keyword_len);
    pf_cmd   = code;
    pf_start = 8'(3 + keyword_len);
  endfunction

  function automatic void open_frame(input logic [7:0] b);
    pf_active = 1'b1;
    pf_pos    = POS_ID;
    pf_len    = 8'd0;
    pf_xor    = b;
    pf_id     = 8'd0;
    pf_c0     = 8'd0;
    pf_c1     = 8'd0;
    pf_cmd    = CMD_UNKNOWN;
    pf_start  = 8'd3;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, output bit emit,
                                       output result_t r);
    logic [7:0] p;
    emit = 1'b0;
    r    = NO_RESULT;
    if (!pf_active) begin
      if (b == marker_q) open_frame(b);
    end else if (pf_pos == POS_ID) begin
      pf_id  = b;
      pf_xor = pf_xor ^ b;
      pf_pos = POS_LEN;
    end else if (pf_pos == POS_LEN) begin
      pf_len = b;
      pf_xor = pf_xor ^ b;
      if (b < MIN_LEN) begin
        pf_cmd    = CMD_UNKNOWN;
        emit      = 1'b1;
        r         = '{KIND_SUMMARY, 8'h00, pf_id, CMD_UNKNOWN, 1'b0};
        pf_active = 1'b0;
        pf_pos    = 8'd0;
      end else begin
        pf_pos = POS_CMD0;
      end
    end else if (pf_pos == pf_len) begin
      emit      = 1'b1;
      r         = '{KIND_SUMMARY, 8'h00, pf_id, pf_cmd, pf_xor == b};
      pf_active = 1'b0;
      pf_pos    = 8'd0;
    end else begin
      pf_xor = pf_xor ^ b;
      if (pf_pos == POS_CMD0) begin
        pf_c0 = b;
        if (b == CHR_E) set_command(CMD_EMPTY, 5);
      end else if (pf_pos == POS_CMD1) begin
        pf_c1 = b;
        if (pf_c0 == CHR_D) begin
          if (b == CHR_E) set_command(CMD_DEPLOY, 6);
          else if (b == CHR_A) set_command(CMD_DATE, 4);
        end else if (pf_c0 == CHR_S) begin
          if (b == CHR_A) set_command(CMD_SAVE, 4);
          else if (b == CHR_U) set_command(CMD_SURVIVAL, 8);
          else if (b == CHR_T) set_command(CMD_STATUS, 6);
        end else if (pf_c0 == CHR_M) begin
          if (b == CHR_I) set_command(CMD_MISSION, 7);
        end
      end else if (pf_pos == POS_CMD2) begin
        if (pf_c0 == CHR_M && pf_c1 == CHR_E) begin
          if (b == CHR_E) set_command(CMD_MEETING, 7);
          else if (b == CHR_A) set_command(CMD_MEASURE, 7);
        end
      end
      p      = pf_pos;
      pf_pos = pf_pos + 8'd1;
      if (pf_cmd != CMD_UNKNOWN && p >= pf_start && ({1'b0, p} + 9'd2) <= {1'b0, pf_len})
      begin
        emit = 1'b1;
        r    = '{KIND_PAYLOAD, b, pf_id, pf_cmd, 1'b0};
      end
    end
  endfunction

  task automatic deliver_byte(input logic [7:0] b, input bit fixed, input bit fixed_emit,
                              input result_t fixed_res);
    bit      emit;
    result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    deframe_byte(b, emit, res);
    if (fixed) begin
      emit = fixed_emit;
      res  = fixed_res;
    end
    if (emit) pending_results.push_back(res);
    phase_bytes++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_marker(input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i        = 1'b1;
    cfg_start_marker_i = value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    marker_q = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic build_frame(input bit long_frame);
    logic [7:0]  len;
    logic [7:0]  b;
    logic [7:0]  sum;
    string       kw;
    int unsigned pick;
    int unsigned k;
    frame_bytes.delete();
    repeat ($urandom_range(0, 2)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    b = 8'($urandom_range(0, 255));
    frame_bytes.push_back(marker_q);
    frame_bytes.push_back(b);
    sum  = marker_q ^ b;
    pick = $urandom_range(99);
    if (long_frame) len = 8'd255;
    else if (pick < 8) len = 8'($urandom_range(0, 2));
    else if (pick < 11) len = 8'($urandom_range(200, 255));
    else len = 8'($urandom_range(3, 24));
    frame_bytes.push_back(len);
    sum = sum ^ len;
    if (len >= MIN_LEN) begin
      k = long_frame ? 8 : $urandom_range(0, 11);
      kw = "";
      if (k < 9) begin
        kw = keywords[k];
      end else if (k < 11) begin
        repeat ($urandom_range(1, 3)) begin
          pick = $urandom_range(0, 7);
          kw = {kw, letters.substr(pick, pick)};
        end
      end
      for (int p = 3; p < len; p++) begin
        if (p - 3 < kw.len()) b = kw[p - 3];
        else b = 8'($urandom_range(0, 255));
        frame_bytes.push_back(b);
        sum = sum ^ b;
      end
      if ($urandom_range(99) < 85) frame_bytes.push_back(sum);
      else frame_bytes.push_back(sum ^ 8'($urandom_range(1, 255)));
    end
    if (!long_frame && $urandom_range(99) < 4) begin
      repeat ($urandom_range(1, 3)) begin
        if (frame_bytes.size() > 1) void'(frame_bytes.pop_back());
      end
    end
  endtask

  task automatic run_random_frames();
    while (phase_bytes < PHASE_BYTES) begin
      build_frame(1'b0);
      foreach (frame_bytes[i]) deliver_byte(frame_bytes[i], 1'b0, 1'b0, NO_RESULT);
      if ($urandom_range(99) < 3) wait_drained();
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        out_stall_i  = 1'b1;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: kind %0h payload_byte %0h", kind_o, payload_byte_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0h, got %0h", want.kind, kind_o);
          errors++;
        end
        if (payload_byte_o !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte, payload_byte_o);
          errors++;
        end
        if (frame_id_o !== want.frame_id) begin
          $error("frame_id: expected %0h, got %0h", want.frame_id, frame_id_o);
          errors++;
        end
        if (command_o !== want.command) begin
          $error("command: expected %0h, got %0h", want.command, command_o);
          errors++;
        end
        if (checksum_ok_o !== want.checksum_ok) begin
          $error("checksum_ok: expected %0h, got %0h", want.checksum_ok, checksum_ok_o);
          errors++;
        end
      end
    end
  end

  initial begin
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_start_marker_i = 8'h00;
    in_valid_i         = 1'b0;
    rx_byte_i          = 8'h00;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 84;
    foreach (DIRECTED_ROWS[i]) begin
      deliver_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].emits,
                   DIRECTED_ROWS[i].res);
    end
    wait_drained();

    write_marker(8'h00);
    phase_bytes = 0;
    run_random_frames();
    wait_drained();

    write_marker(8'hFF);
    send_idle_pct = 84;
    recv_idle_pct = 33;
    phase_bytes = 0;
    run_random_frames();
    wait_drained();

    write_marker(8'($urandom_range(0, 255)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_bytes = 0;
    @(posedge clk_i);
    hold_request = 1'b1;
    build_frame(1'b1);
    foreach (frame_bytes[i]) deliver_byte(frame_bytes[i], 1'b0, 1'b0, NO_RESULT);
    run_random_frames();
    wait_drained();

    if (errors == 0) begin
      $display("command_frame_deframer_top_tb: clean");
    end else begin
      $display("command_frame_deframer_top_tb: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/cfd_pkg.sv
sv/cfd_input_stage.sv
sv/cfd_parser.sv
sv/cfd_output_stage.sv
sv/command_frame_deframer_top.sv
sv/cfd_checker.sv
tb/command_frame_deframer_top_tb.sv
